// ===== hdl/blr_pkg.sv =====
// Shared types, constants and helpers for the longest-run image core.
// No dependencies; imported by every module of the block.
package blr_pkg;

  localparam int MAX_DIM = 64;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int LEN_W   = $clog2(MAX_DIM + 1);
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 1;

  // Register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [IDX_W-1:0] REG_NUM_COLS = 1'b1;

  // One pixel with its position, as held in the input stage
  typedef struct packed {
    logic             pix;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic             row_end;
    logic             frame_end;
  } pix_item_t;

  // Column memory write port, from the run stage to the memory
  typedef struct packed {
    logic             en;
    logic [DIM_W-1:0] addr;
    logic [LEN_W-1:0] data;
    logic             frame_clr;
  } col_wr_t;

  // Zero counts as one, anything above the maximum as the maximum
  function automatic logic [LEN_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = LEN_W'(MAX_DIM);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== hdl/blr_pos.sv =====
// Configuration registers, raster position counters and the input stage.
// Depends on blr_pkg.
module blr_pos (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [blr_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [blr_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     pixel_i,
  input  logic                     adv_i,
  output logic                     cfg_clr_o,
  output logic                     s1_valid_o,
  output blr_pkg::pix_item_t       s1_item_o
);
  import blr_pkg::*;

  logic [CFG_W-1:0] num_rows_q, num_cols_q;
  logic [DIM_W-1:0] col_pos_q, row_pos_q;
  logic             s1_valid_q;
  pix_item_t        s1_item_q;
  logic [LEN_W-1:0] rows_eff, cols_eff;
  logic             accept, row_end, frame_end;

  assign rows_eff  = eff_dim(num_rows_q);
  assign cols_eff  = eff_dim(num_cols_q);
  assign accept    = in_valid_i && adv_i;
  assign row_end   = (LEN_W'(col_pos_q) + LEN_W'(1)) == cols_eff;
  assign frame_end = row_end && ((LEN_W'(row_pos_q) + LEN_W'(1)) == rows_eff);

  // Any known register index restarts the frame
  always_comb begin
    cfg_clr_o = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NUM_ROWS: cfg_clr_o = 1'b1;
        REG_NUM_COLS: cfg_clr_o = 1'b1;
        default:      cfg_clr_o = 1'b0;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= CFG_W'(MAX_DIM);
      num_cols_q <= CFG_W'(MAX_DIM);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NUM_ROWS: num_rows_q <= cfg_wdata_i;
        REG_NUM_COLS: num_cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Raster position, advanced per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
    end else if (cfg_clr_o) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_pos_q <= '0;
        row_pos_q <= frame_end ? '0 : row_pos_q + DIM_W'(1);
      end else begin
        col_pos_q <= col_pos_q + DIM_W'(1);
      end
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.pix       <= pixel_i;
      s1_item_q.col       <= col_pos_q;
      s1_item_q.row       <= row_pos_q;
      s1_item_q.row_end   <= row_end;
      s1_item_q.frame_end <= frame_end;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;

endmodule

// ===== hdl/blr_colmem.sv =====
// Per-column run counters: memory with registered read, valid bits and
// a write-to-read bypass. Depends on blr_pkg.
module blr_colmem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      cfg_clr_i,
  input  logic                      s1_valid_i,
  input  blr_pkg::pix_item_t        s1_item_i,
  input  blr_pkg::col_wr_t          wr_i,
  output logic [blr_pkg::LEN_W-1:0] prev_o
);
  import blr_pkg::*;

  logic [LEN_W-1:0] mem [MAX_DIM];
  logic [MAX_DIM-1:0] vld_q;
  logic [LEN_W-1:0] rd_q, byp_data_q;
  logic             ok_q, byp_q;
  logic             clr_all, rd_en;

  assign clr_all = cfg_clr_i || (wr_i.en && wr_i.frame_clr);
  assign rd_en   = adv_i && s1_valid_i;

  // Array write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      rd_q       <= mem[s1_item_i.col];
      byp_data_q <= wr_i.data;
    end
  end

  // Valid bits; a frame end or a configuration write clears every entry at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_all) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // Read qualifiers: entry valid, or same column written this cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q  <= 1'b0;
      byp_q <= 1'b0;
    end else if (rd_en) begin
      ok_q  <= vld_q[s1_item_i.col] && !clr_all;
      byp_q <= wr_i.en && (wr_i.addr == s1_item_i.col) && !clr_all;
    end
  end

  assign prev_o = byp_q ? byp_data_q : (ok_q ? rd_q : '0);

endmodule

// ===== hdl/blr_best.sv =====
// Run stage: column and row run update, best-run tracking and the result
// register. Depends on blr_pkg.
module blr_best (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_clr_i,
  input  logic                      s1_valid_i,
  input  blr_pkg::pix_item_t        s1_item_i,
  input  logic [blr_pkg::LEN_W-1:0] prev_i,
  input  logic                      out_stall_i,
  output logic                      adv_o,
  output blr_pkg::col_wr_t          wr_o,
  output logic                      out_valid_o,
  output logic [blr_pkg::LEN_W-1:0] vert_len_o,
  output logic [blr_pkg::DIM_W-1:0] vert_top_row_o,
  output logic [blr_pkg::DIM_W-1:0] vert_col_o,
  output logic [blr_pkg::LEN_W-1:0] horiz_len_o,
  output logic [blr_pkg::DIM_W-1:0] horiz_row_o,
  output logic [blr_pkg::DIM_W-1:0] horiz_left_col_o
);
  import blr_pkg::*;

  logic             s2_valid_q;
  pix_item_t        s2_q;
  logic [LEN_W-1:0] row_run_q, row_run_d, run;
  logic [LEN_W-1:0] bvl_q, bvl_d, bhl_q, bhl_d, h;
  logic [DIM_W-1:0] bvr_q, bvr_d, bvc_q, bvc_d, bhr_q, bhr_d, bhc_q, bhc_d;
  logic             vert_win, horiz_win, work, emit;
  logic             out_valid_q;
  logic [LEN_W-1:0] top_full, left_full;

  // Pipeline holds only when a result is due and the last one is stuck
  assign adv_o = !(s2_valid_q && s2_q.frame_end && out_valid_q && out_stall_i);
  assign work  = adv_o && s2_valid_q;
  assign emit  = work && s2_q.frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_o) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && s1_valid_i) begin
      s2_q <= s1_item_i;
    end
  end

  // Run lengths for this pixel
  assign h   = s2_q.pix ? prev_i + LEN_W'(1) : '0;
  assign run = s2_q.pix ? row_run_q + LEN_W'(1) : '0;

  // Vertical ties favor the higher column, then the lower end
  assign vert_win = s2_q.pix && ((h > bvl_q) || ((h == bvl_q) &&
                    ((s2_q.col > bvc_q) || ((s2_q.col == bvc_q) && (s2_q.row >= bvr_q)))));
  // Horizontal ties keep the first run
  assign horiz_win = s2_q.pix && (run > bhl_q);

  always_comb begin
    bvl_d = bvl_q;
    bvr_d = bvr_q;
    bvc_d = bvc_q;
    bhl_d = bhl_q;
    bhr_d = bhr_q;
    bhc_d = bhc_q;
    if (vert_win) begin
      bvl_d = h;
      bvr_d = s2_q.row;
      bvc_d = s2_q.col;
    end
    if (horiz_win) begin
      bhl_d = run;
      bhr_d = s2_q.row;
      bhc_d = s2_q.col;
    end
    row_run_d = s2_q.row_end ? '0 : run;
  end

  // Column counter write-back
  assign wr_o.en        = work;
  assign wr_o.addr      = s2_q.col;
  assign wr_o.data      = h;
  assign wr_o.frame_clr = s2_q.frame_end;

  // Best-run state, cleared at each frame end and on a configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_run_q <= '0;
      bvl_q     <= '0;
      bvr_q     <= '0;
      bvc_q     <= '0;
      bhl_q     <= '0;
      bhr_q     <= '0;
      bhc_q     <= '0;
    end else if (cfg_clr_i || emit) begin
      row_run_q <= '0;
      bvl_q     <= '0;
      bvr_q     <= '0;
      bvc_q     <= '0;
      bhl_q     <= '0;
      bhr_q     <= '0;
      bhc_q     <= '0;
    end else if (work) begin
      row_run_q <= row_run_d;
      bvl_q     <= bvl_d;
      bvr_q     <= bvr_d;
      bvc_q     <= bvc_d;
      bhl_q     <= bhl_d;
      bhr_q     <= bhr_d;
      bhc_q     <= bhc_d;
    end
  end

  // Start coordinates from end coordinates
  assign top_full  = LEN_W'(bvr_d) + LEN_W'(1) - bvl_d;
  assign left_full = LEN_W'(bhc_d) + LEN_W'(1) - bhl_d;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      vert_len_o       <= bvl_d;
      vert_top_row_o   <= (bvl_d != '0) ? top_full[DIM_W-1:0] : '0;
      vert_col_o       <= (bvl_d != '0) ? bvc_d : '0;
      horiz_len_o      <= bhl_d;
      horiz_row_o      <= (bhl_d != '0) ? bhr_d : '0;
      horiz_left_col_o <= (bhl_d != '0) ? left_full[DIM_W-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/binary_image_longest_runs_core.sv =====
// Longest vertical and horizontal black runs of a raster-order binary image.
// The last pixel passes the input stage and run stage, then loads the result register.
// Throughput: one pixel per cycle unless stalled, set by the column counter memory port.
// Input stalls only while a frame result is due and the previous one waits.
// Reset (async, active low): sizes 64x64, counters and position cleared.
// Top level; depends on blr_pkg, blr_pos, blr_colmem and blr_best.
module binary_image_longest_runs_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [blr_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [blr_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      pixel_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [blr_pkg::LEN_W-1:0] vert_len_o,
  output logic [blr_pkg::DIM_W-1:0] vert_top_row_o,
  output logic [blr_pkg::DIM_W-1:0] vert_col_o,
  output logic [blr_pkg::LEN_W-1:0] horiz_len_o,
  output logic [blr_pkg::DIM_W-1:0] horiz_row_o,
  output logic [blr_pkg::DIM_W-1:0] horiz_left_col_o
);
  import blr_pkg::*;

  logic             adv, cfg_clr, s1_valid;
  pix_item_t        s1_item;
  col_wr_t          col_wr;
  logic [LEN_W-1:0] prev;

  assign in_stall_o = !adv;

  blr_pos u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .pixel_i     (pixel_i),
    .adv_i       (adv),
    .cfg_clr_o   (cfg_clr),
    .s1_valid_o  (s1_valid),
    .s1_item_o   (s1_item)
  );

  blr_colmem u_colmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .cfg_clr_i  (cfg_clr),
    .s1_valid_i (s1_valid),
    .s1_item_i  (s1_item),
    .wr_i       (col_wr),
    .prev_o     (prev)
  );

  blr_best u_best (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_clr_i        (cfg_clr),
    .s1_valid_i       (s1_valid),
    .s1_item_i        (s1_item),
    .prev_i           (prev),
    .out_stall_i      (out_stall_i),
    .adv_o            (adv),
    .wr_o             (col_wr),
    .out_valid_o      (out_valid_o),
    .vert_len_o       (vert_len_o),
    .vert_top_row_o   (vert_top_row_o),
    .vert_col_o       (vert_col_o),
    .horiz_len_o      (horiz_len_o),
    .horiz_row_o      (horiz_row_o),
    .horiz_left_col_o (horiz_left_col_o)
  );

`ifndef SYNTHESIS
  // Input back-pressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // Run lengths never exceed the largest image side
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((32'(vert_len_o) <= MAX_DIM) && (32'(horiz_len_o) <= MAX_DIM)))
    else $error("run length out of range");

  // A vertical run fits inside the image
  a_vert_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((32'(vert_top_row_o) + 32'(vert_len_o)) <= MAX_DIM))
    else $error("vertical run extends past the last row");

  // A horizontal run fits inside the image
  a_horiz_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((32'(horiz_left_col_o) + 32'(horiz_len_o)) <= MAX_DIM))
    else $error("horizontal run extends past the last column");
`endif

endmodule

// ===== sim/binary_image_longest_runs_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for binary_image_longest_runs_core: scripted small frames
// with written expectations, then random frames checked against a local run tracker.
// Depends on blr_pkg and the core RTL only.
module binary_image_longest_runs_core_test;
  import blr_pkg::*;

  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 10;
  localparam int PRINT_LIMIT  = 50;

  // One frame result, field for field as on the output ports
  typedef struct packed {
    logic [LEN_W-1:0] vert_len;
    logic [DIM_W-1:0] vert_top;
    logic [DIM_W-1:0] vert_col;
    logic [LEN_W-1:0] horiz_len;
    logic [DIM_W-1:0] horiz_row;
    logic [DIM_W-1:0] horiz_left;
  } runs_t;

  typedef enum logic {PLAN_CFG, PLAN_PIX} plan_kind_e;

  // One row of the scripted part
  typedef struct packed {
    plan_kind_e       kind;
    logic             set_rows;
    logic             set_cols;
    logic [CFG_W-1:0] rows_val;
    logic [CFG_W-1:0] cols_val;
    logic             pix;
    logic             typed;
    runs_t            want;
  } plan_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic             pixel_i     = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [LEN_W-1:0] vert_len_o;
  logic [DIM_W-1:0] vert_top_row_o;
  logic [DIM_W-1:0] vert_col_o;
  logic [LEN_W-1:0] horiz_len_o;
  logic [DIM_W-1:0] horiz_row_o;
  logic [DIM_W-1:0] horiz_left_col_o;

  binary_image_longest_runs_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_i          (pixel_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .vert_len_o       (vert_len_o),
    .vert_top_row_o   (vert_top_row_o),
    .vert_col_o       (vert_col_o),
    .horiz_len_o      (horiz_len_o),
    .horiz_row_o      (horiz_row_o),
    .horiz_left_col_o (horiz_left_col_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Run tracker state: sizes, per-column runs, raster position, best runs
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  logic [LEN_W-1:0] col_runs [MAX_DIM];
  logic [DIM_W-1:0] row_at, col_at;
  logic [LEN_W-1:0] row_run;
  logic [LEN_W-1:0] best_vlen, best_hlen;
  logic [DIM_W-1:0] best_vend, best_vcol, best_hrow, best_hend;

  runs_t     pending_runs [$];
  plan_row_t plan [$];
  int        run_errors    = 0;
  int        pixels_sent   = 0;
  int        frames_closed = 0;
  bit        quiet_stretch = 1'b0;

  function automatic runs_t make_runs(input logic [LEN_W-1:0] vl, input logic [DIM_W-1:0] vt,
                                      input logic [DIM_W-1:0] vc, input logic [LEN_W-1:0] hl,
                                      input logic [DIM_W-1:0] hr, input logic [DIM_W-1:0] hc);
    runs_t r;
    r.vert_len   = vl;
    r.vert_top   = vt;
    r.vert_col   = vc;
    r.horiz_len  = hl;
    r.horiz_row  = hr;
    r.horiz_left = hc;
    return r;
  endfunction

  // Zero means one row/column, anything past the maximum means the maximum
  function automatic int frame_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void clear_runs();
    foreach (col_runs[i]) col_runs[i] = '0;
    row_at    = '0;
    col_at    = '0;
    row_run   = '0;
    best_vlen = '0;
    best_vend = '0;
    best_vcol = '0;
    best_hlen = '0;
    best_hrow = '0;
    best_hend = '0;
  endfunction

  // Advance the tracker by one pixel; returns 1 with the frame result on the last one
  function automatic bit track_pixel(input logic pix, output runs_t res);
    int n_rows, n_cols, h;
    n_rows = frame_dim(rows_reg);
    n_cols = frame_dim(cols_reg);
    res = '0;
    if (pix) begin
      col_runs[col_at] = col_runs[col_at] + LEN_W'(1);
      h = int'(col_runs[col_at]);
      // vertical ties: highest column, then highest end row index
      if (h > int'(best_vlen) ||
          (h == int'(best_vlen) && (col_at > best_vcol ||
           (col_at == best_vcol && row_at >= best_vend)))) begin
        best_vlen = LEN_W'(h);
        best_vend = row_at;
        best_vcol = col_at;
      end
      // horizontal ties: first in raster order keeps it
      row_run = row_run + LEN_W'(1);
      if (row_run > best_hlen) begin
        best_hlen = row_run;
        best_hrow = row_at;
        best_hend = col_at;
      end
    end else begin
      col_runs[col_at] = '0;
      row_run = '0;
    end
    if (int'(col_at) + 1 >= n_cols) begin
      col_at  = '0;
      row_run = '0;
      if (int'(row_at) + 1 >= n_rows) begin
        res.vert_len  = best_vlen;
        res.horiz_len = best_hlen;
        if (best_vlen != '0) begin
          res.vert_top = DIM_W'(int'(best_vend) + 1 - int'(best_vlen));
          res.vert_col = best_vcol;
        end
        if (best_hlen != '0) begin
          res.horiz_row  = best_hrow;
          res.horiz_left = DIM_W'(int'(best_hend) + 1 - int'(best_hlen));
        end
        clear_runs();
        return 1'b1;
      end
      row_at = row_at + DIM_W'(1);
    end else begin
      col_at = col_at + DIM_W'(1);
    end
    return 1'b0;
  endfunction

  function automatic bit idle_now();
    return !quiet_stretch && ($urandom_range(99) < 27);
  endfunction

  task automatic report_mismatch(input string msg);
    if (run_errors < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
    run_errors++;
  endtask

  task automatic cmp_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Compare one accepted frame result with the oldest expectation
  task automatic check_frame(input runs_t got);
    runs_t want;
    if (pending_runs.size() == 0) begin
      report_mismatch("frame result with nothing expected");
      return;
    end
    want = pending_runs.pop_front();
    cmp_field("vert_len", int'(got.vert_len), int'(want.vert_len));
    cmp_field("vert_top_row", int'(got.vert_top), int'(want.vert_top));
    cmp_field("vert_col", int'(got.vert_col), int'(want.vert_col));
    cmp_field("horiz_len", int'(got.horiz_len), int'(want.horiz_len));
    cmp_field("horiz_row", int'(got.horiz_row), int'(want.horiz_row));
    cmp_field("horiz_left_col", int'(got.horiz_left), int'(want.horiz_left));
  endtask

  // Result side: random stall, check each transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_frame(make_runs(vert_len_o, vert_top_row_o, vert_col_o,
                            horiz_len_o, horiz_row_o, horiz_left_col_o));
    end
    out_stall_i <= idle_now();
  end

  // Drop valid, wait for every expected result, then let the pipeline drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input bit set_rows, input logic [CFG_W-1:0] rows_val,
                           input bit set_cols, input logic [CFG_W-1:0] cols_val);
    settle();
    if (set_rows) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= REG_NUM_ROWS;
      cfg_wdata_i <= rows_val;
      @(posedge clk_i);
      rows_reg = rows_val;
      clear_runs();
    end
    if (set_cols) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= REG_NUM_COLS;
      cfg_wdata_i <= cols_val;
      @(posedge clk_i);
      cols_reg = cols_val;
      clear_runs();
    end
    cfg_we_i <= 1'b0;
  endtask

  // Send one pixel; valid stays high after the transaction for a back-to-back next one
  task automatic send_pixel(input logic pix, input bit typed, input runs_t typed_want);
    runs_t res;
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= pix;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixels_sent++;
    if (track_pixel(pix, res)) begin
      frames_closed++;
      pending_runs.push_back(typed ? typed_want : res);
    end else if (typed) begin
      report_mismatch("scripted frame did not close where expected");
    end
  endtask

  task automatic add_cfg(input bit sr, input logic [CFG_W-1:0] rv,
                         input bit sc, input logic [CFG_W-1:0] cv);
    plan_row_t p;
    p = '0;
    p.kind     = PLAN_CFG;
    p.set_rows = sr;
    p.rows_val = rv;
    p.set_cols = sc;
    p.cols_val = cv;
    plan.push_back(p);
  endtask

  task automatic add_pix(input logic pix, input bit typed, input runs_t want);
    plan_row_t p;
    p = '0;
    p.kind  = PLAN_PIX;
    p.pix   = pix;
    p.typed = typed;
    p.want  = want;
    plan.push_back(p);
  endtask

  // Watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int shade [5];
    int n_frames, frame_px, density, cut;
    bit set_r, set_c;
    logic [CFG_W-1:0] rv, cv;
    runs_t none;

    shade = '{0, 15, 50, 85, 100};
    none  = '0;
    rows_reg = CFG_W'(MAX_DIM);
    cols_reg = CFG_W'(MAX_DIM);
    clear_runs();

    // Scripted frames
    // 1x1 (rows register zero): all white gives zeros, one black pixel
    add_cfg(1'b1, 7'd0, 1'b1, 7'd1);
    add_pix(1'b0, 1'b1, none);
    add_pix(1'b1, 1'b1, make_runs(7'd1, 6'd0, 6'd0, 7'd1, 6'd0, 6'd0));
    // 2x2 all black: vertical tie to the right column, horizontal to the first row
    add_cfg(1'b1, 7'd2, 1'b1, 7'd2);
    add_pix(1'b1, 1'b0, none);
    add_pix(1'b1, 1'b0, none);
    add_pix(1'b1, 1'b0, none);
    add_pix(1'b1, 1'b1, make_runs(7'd2, 6'd0, 6'd1, 7'd2, 6'd0, 6'd0));
    add_pix(1'b0, 1'b0, none);
    add_pix(1'b1, 1'b0, none);
    add_pix(1'b1, 1'b0, none);
    add_pix(1'b0, 1'b0, none);
    // frame abandoned by a register write, then a fresh 2x2
    add_cfg(1'b0, 7'd0, 1'b1, 7'd3);
    add_pix(1'b1, 1'b0, none);
    add_pix(1'b1, 1'b0, none);
    add_cfg(1'b0, 7'd0, 1'b1, 7'd2);
    add_pix(1'b1, 1'b0, none);
    add_pix(1'b0, 1'b0, none);
    add_pix(1'b1, 1'b0, none);
    add_pix(1'b1, 1'b0, none);
    // 1x3: run starting off the left edge
    add_cfg(1'b1, 7'd1, 1'b1, 7'd3);
    add_pix(1'b0, 1'b0, none);
    add_pix(1'b1, 1'b0, none);
    add_pix(1'b1, 1'b1, make_runs(7'd1, 6'd0, 6'd2, 7'd2, 6'd0, 6'd1));
    // 3x1: equal vertical runs in one column, lower one wins
    add_cfg(1'b1, 7'd3, 1'b1, 7'd1);
    add_pix(1'b1, 1'b0, none);
    add_pix(1'b0, 1'b0, none);
    add_pix(1'b1, 1'b1, make_runs(7'd1, 6'd2, 6'd0, 7'd1, 6'd0, 6'd0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == PLAN_CFG) begin
        configure(plan[i].set_rows, plan[i].rows_val, plan[i].set_cols, plan[i].cols_val);
      end else begin
        send_pixel(plan[i].pix, plan[i].typed, plan[i].want);
      end
    end

    // Random frames: extreme sizes first, then mostly small ones
    for (int ph = 0; pixels_sent < 700 || frames_closed < 40; ph++) begin
      quiet_stretch = (ph >= 6 && ph < 10);
      set_r = 1'b1;
      set_c = 1'b1;
      case (ph)
        0: begin rv = 7'd127; cv = 7'd1;   end
        1: begin rv = 7'd1;   cv = 7'd127; end
        2: begin rv = 7'd0;   cv = 7'd0;   end
        3: begin rv = 7'd64;  cv = 7'd2;   end
        default: begin
          set_r = 1'($urandom_range(1));
          set_c = !set_r || $urandom_range(1);
          rv = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(9, 16))
                                        : CFG_W'($urandom_range(1, 8));
          cv = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(9, 16))
                                        : CFG_W'($urandom_range(1, 8));
        end
      endcase
      configure(set_r, rv, set_c, cv);
      frame_px = frame_dim(rows_reg) * frame_dim(cols_reg);
      n_frames = (ph < 4) ? 2 : $urandom_range(1, 4);
      for (int f = 0; f < n_frames; f++) begin
        density = (ph < 4 && f == 0) ? 100 : shade[$urandom_range(4)];
        for (int k = 0; k < frame_px; k++) begin
          send_pixel($urandom_range(99) < density, 1'b0, none);
        end
      end
      // sometimes leave a frame half done for the next write to abandon
      if (frame_px > 1 && $urandom_range(4) == 0) begin
        cut = $urandom_range(1, frame_px - 1);
        for (int k = 0; k < cut; k++) send_pixel(1'($urandom_range(1)), 1'b0, none);
      end
    end
    quiet_stretch = 1'b0;

    in_valid_i <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (run_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/blr_pkg.sv
hdl/blr_pos.sv
hdl/blr_colmem.sv
hdl/blr_best.sv
hdl/binary_image_longest_runs_core.sv
sim/binary_image_longest_runs_core_test.sv
